### rtl/selective_ack_scoreboard_unit_macros.svh
// assertion macros shared by the scoreboard rtl
// no dependencies; expects aclk and aresetn in the including module
`ifndef SELECTIVE_ACK_SCOREBOARD_UNIT_MACROS_SVH
`define SELECTIVE_ACK_SCOREBOARD_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define SASB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SASB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SASB_ASSERT_NOW(lbl, ante, cons, msg)
`define SASB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/sasb_pkg.sv
// shared constants, opcodes and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps

package sasb_pkg;

    localparam int WINDOW      = 64;
    localparam int NUMBER_BITS = 32;
    localparam int PTR_W       = NUMBER_BITS + 1;
    localparam int IDX_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);

    // bitmap is swept eight bits at a time for popcount and run search
    localparam int CHUNK       = 8;
    localparam int CHUNK_CNT_W = $clog2(CHUNK + 1);
    localparam int CHUNKS      = (WINDOW + CHUNK - 1) / CHUNK;
    localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int PAD_BITS    = CHUNKS * CHUNK;

    typedef enum logic [1:0] {
        OP_CONFIRM_ONE = 2'd0,
        OP_CONFIRM_TO  = 2'd1,
        OP_QUERY       = 2'd2,
        OP_COUNT       = 2'd3
    } op_t;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic mark_oow;
        logic set_bit;
        logic query;
        logic pop_step;
        logic count_done;
        logic drop;
        logic adv_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic below;
        logic in_window;
        logic chunk_last;
        logic adv_done;
    } dp_status_t;

endpackage

### rtl/sasb_datapath.sv
// pointer, bitmap, popcount accumulator and result registers
// depends on sasb_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "selective_ack_scoreboard_unit_macros.svh"

module sasb_datapath
    import sasb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [1:0]        in_operation,
    input  logic [31:0]       in_number,
    output logic              out_flag,
    output logic [PTR_W-1:0]  out_count,
    output logic [PTR_W-1:0]  out_pointer,
    output logic              out_oow
);

    logic [PTR_W-1:0]       fu_reg, fu_next;
    logic [WINDOW-1:0]      bitmap_reg, bitmap_next;
    op_t                    op_reg, op_next;
    logic [NUMBER_BITS-1:0] n_reg, n_next;
    logic                   below_reg, below_next;
    logic [PTR_W-1:0]       off_reg, off_next;
    logic [CNT_W-1:0]       acc_reg, acc_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic                   flag_reg, flag_next;
    logic [PTR_W-1:0]       count_reg, count_next;
    logic                   oow_reg, oow_next;
    logic                   oflag_reg, oflag_next;
    logic [PTR_W-1:0]       ocount_reg, ocount_next;
    logic [PTR_W-1:0]       optr_reg, optr_next;
    logic                   ooow_reg, ooow_next;

    logic [PTR_W:0]         diff;
    logic                   in_window;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       lim;
    logic [PAD_BITS-1:0]    pad_vec;
    logic [CHUNK-1:0]       pop_bits;
    logic [CHUNK_CNT_W-1:0] chunk_pop;
    logic [CHUNK-1:0]       low_bits;
    logic [CHUNK_CNT_W-1:0] run_len;
    logic                   run_stop;
    logic                   drop_all;
    logic [IDX_W:0]         drop_shift;

    assign diff      = {2'b00, n_reg} - {1'b0, fu_reg};
    assign in_window = off_reg < PTR_W'(WINDOW);
    assign idx       = off_reg[IDX_W-1:0];
    assign lim       = in_window ? idx : IDX_W'(WINDOW - 1);
    assign pad_vec   = PAD_BITS'(bitmap_reg);
    assign pop_bits  = pad_vec[chunk_reg * CHUNK +: CHUNK];
    assign low_bits  = bitmap_reg[CHUNK-1:0];
    assign drop_all  = off_reg >= PTR_W'(WINDOW - 1);
    assign drop_shift = {1'b0, idx} + (IDX_W + 1)'(1);

    // masked popcount of the current chunk, bits above the limit excluded
    always_comb begin
        chunk_pop = '0;
        for (int j = 0; j < CHUNK; j++) begin
            if (pop_bits[j] && (int'(chunk_reg) * CHUNK + j <= int'(lim))) begin
                chunk_pop = chunk_pop + CHUNK_CNT_W'(1);
            end
        end
    end

    // run of ones at the bottom of the low chunk
    always_comb begin
        run_len  = '0;
        run_stop = 1'b0;
        for (int j = 0; j < CHUNK; j++) begin
            if (!run_stop && low_bits[j]) begin
                run_len = run_len + CHUNK_CNT_W'(1);
            end else begin
                run_stop = 1'b1;
            end
        end
    end

    always_comb begin
        fu_next     = fu_reg;
        bitmap_next = bitmap_reg;
        op_next     = op_reg;
        n_next      = n_reg;
        below_next  = below_reg;
        off_next    = off_reg;
        acc_next    = acc_reg;
        chunk_next  = chunk_reg;
        flag_next   = flag_reg;
        count_next  = count_reg;
        oow_next    = oow_reg;
        oflag_next  = oflag_reg;
        ocount_next = ocount_reg;
        optr_next   = optr_reg;
        ooow_next   = ooow_reg;

        if (cmd.load_item) begin
            op_next = op_t'(in_operation);
            n_next  = in_number[NUMBER_BITS-1:0];
        end
        if (cmd.decode) begin
            below_next = diff[PTR_W];
            off_next   = diff[PTR_W-1:0];
            acc_next   = '0;
            chunk_next = '0;
            flag_next  = 1'b0;
            count_next = '0;
            oow_next   = 1'b0;
        end
        if (cmd.mark_oow) begin
            oow_next = 1'b1;
        end
        if (cmd.set_bit) begin
            flag_next        = !bitmap_reg[idx];
            bitmap_next[idx] = 1'b1;
        end
        if (cmd.query) begin
            flag_next = below_reg | (in_window & bitmap_reg[idx]);
        end
        if (cmd.pop_step) begin
            acc_next   = acc_reg + CNT_W'(chunk_pop);
            chunk_next = chunk_reg + CHUNK_IDX_W'(1);
        end
        if (cmd.count_done) begin
            count_next = off_reg + PTR_W'(1) - PTR_W'(acc_reg);
        end
        if (cmd.drop) begin
            bitmap_next = drop_all ? '0 : (bitmap_reg >> drop_shift);
            fu_next     = {1'b0, n_reg} + PTR_W'(1);
        end
        if (cmd.adv_step) begin
            if (&low_bits) begin
                bitmap_next = bitmap_reg >> CHUNK;
                fu_next     = fu_reg + PTR_W'(CHUNK);
            end else begin
                bitmap_next = bitmap_reg >> run_len;
                fu_next     = fu_reg + PTR_W'(run_len);
            end
        end
        if (cmd.load_out) begin
            oflag_next  = flag_reg;
            ocount_next = count_reg;
            optr_next   = fu_reg;
            ooow_next   = oow_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fu_reg     <= '0;
            bitmap_reg <= '0;
        end else begin
            fu_reg     <= fu_next;
            bitmap_reg <= bitmap_next;
        end
        op_reg     <= op_next;
        n_reg      <= n_next;
        below_reg  <= below_next;
        off_reg    <= off_next;
        acc_reg    <= acc_next;
        chunk_reg  <= chunk_next;
        flag_reg   <= flag_next;
        count_reg  <= count_next;
        oow_reg    <= oow_next;
        oflag_reg  <= oflag_next;
        ocount_reg <= ocount_next;
        optr_reg   <= optr_next;
        ooow_reg   <= ooow_next;
    end

    assign status.op         = op_reg;
    assign status.below      = below_reg;
    assign status.in_window  = in_window;
    assign status.chunk_last = chunk_reg == CHUNK_IDX_W'(CHUNKS - 1);
    assign status.adv_done   = !(&low_bits);

    assign out_flag    = oflag_reg;
    assign out_count   = ocount_reg;
    assign out_pointer = optr_reg;
    assign out_oow     = ooow_reg;

    // bottom bit is always consumed by the run search before the next item
    `SASB_ASSERT_NOW(a_bit0_clear, cmd.load_item, !bitmap_reg[0], "bitmap bit 0 set at new item")
    `SASB_ASSERT_NOW(a_ptr_bound, 1'b1, fu_reg <= (PTR_W'(1) << NUMBER_BITS),
        "pointer beyond number space")

endmodule

### rtl/sasb_controller.sv
// sequencing state machine for the scoreboard, owns both handshakes
// depends on sasb_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "selective_ack_scoreboard_unit_macros.svh"

module sasb_controller
    import sasb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_COUNT,
        ST_COUNT_END,
        ST_DROP,
        ST_ADVANCE,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (status.op)
                    OP_CONFIRM_ONE: begin
                        if (status.below) begin
                            state_next = ST_RESULT;
                        end else if (!status.in_window) begin
                            cmd.mark_oow = 1'b1;
                            state_next   = ST_RESULT;
                        end else begin
                            cmd.set_bit = 1'b1;
                            state_next  = ST_ADVANCE;
                        end
                    end
                    OP_QUERY: begin
                        cmd.query  = 1'b1;
                        state_next = ST_RESULT;
                    end
                    default: begin
                        state_next = status.below ? ST_RESULT : ST_COUNT;
                    end
                endcase
            end
            ST_COUNT: begin
                cmd.pop_step = 1'b1;
                if (status.chunk_last) begin
                    state_next = ST_COUNT_END;
                end
            end
            ST_COUNT_END: begin
                cmd.count_done = 1'b1;
                state_next = (status.op == OP_CONFIRM_TO) ? ST_DROP : ST_RESULT;
            end
            ST_DROP: begin
                cmd.drop   = 1'b1;
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                cmd.adv_step = 1'b1;
                if (status.adv_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    `SASB_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_valid_reg || m_ready,
        "result overwritten before transfer")
    `SASB_ASSERT_NEXT(a_accept_decode, s_valid && s_ready, state_reg == ST_DECODE,
        "accepted item not decoded")
    `SASB_ASSERT_NOW(a_advance_op, state_reg == ST_ADVANCE,
        status.op == OP_CONFIRM_ONE || status.op == OP_CONFIRM_TO,
        "pointer advance on a query")

endmodule

### rtl/selective_ack_scoreboard_unit.sv
// top level of the selective acknowledge scoreboard
// depends on sasb_pkg, sasb_controller and sasb_datapath
`timescale 1ns / 1ps
//
// Tracks confirmed packet numbers as a cumulative pointer plus a bitmap of
// out-of-order confirmations above it. One operation is taken on the s_
// channel (valid/ready) and exactly one result leaves on the m_ channel.
// Operations: confirm one, confirm up to, query confirmed, count unconfirmed.
// Steps from input transfer to result valid:
//   query, confirm one outside the window, or any op below the pointer:
//     decode, execute, result; confirm one: decode, execute, advance, result
//   count: decode, execute, count sweep, count end, result
//   confirm up to: as count, then drop and advance steps before the result
// An advance step shifts out up to 8 bits of leading confirmed run; the
// count sweep reads the bitmap 8 bits a cycle.
// One item is in flight at a time; the next is taken once the result is
// loaded into the output register, so s_ready stays high while a finished
// result waits on m_ready. If the receiver stalls with a result already held,
// the next result waits in its last step and no further item is taken.
// Synchronous active-low reset clears the pointer and bitmap.
//
module selective_ack_scoreboard_unit
    import sasb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_packet_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_flag,
    output logic [32:0] m_unconfirmed_count,
    output logic [32:0] m_first_unconfirmed_out,
    output logic        m_out_of_window
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sasb_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sasb_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_operation (s_operation),
        .in_number    (s_packet_number),
        .out_flag     (m_flag),
        .out_count    (m_unconfirmed_count),
        .out_pointer  (m_first_unconfirmed_out),
        .out_oow      (m_out_of_window)
    );

endmodule
